FILE: rtl/gbm_pkg.sv
// Shared types, constants and coefficient tables for the Gaussian pair generator.
package gbm_pkg;

	localparam int UNIFORM_BITS_DEF = 32;

	localparam int SQ_STEPS     = 30;
	localparam int SQRT_STEPS   = 32;
	localparam int HORNER_STEPS = 8;

	localparam int LOG_LAT  = 1 + SQ_STEPS + 2 + SQRT_STEPS;
	localparam int QSIN_LAT = 2 + 3 * HORNER_STEPS + 1;
	localparam int TRIG_LAT = 1 + QSIN_LAT;
	localparam int OUT_LAT  = 3;
	localparam int TOTAL_LAT = LOG_LAT + OUT_LAT;

	localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

	localparam logic [31:0] MEAN_RESET   = 32'd0;
	localparam logic [30:0] SPREAD_RESET = 31'd65536;

	typedef enum logic [0:0] {
		REG_MEAN   = 1'b0,
		REG_SPREAD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] uniform_radius;
		logic [31:0] uniform_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] normal_cos;
		logic signed [31:0] normal_sin;
	} out_item_t;

	function automatic logic [8:0] sin_div(input int j);
		logic [8:0] d;
		case (j)
			0: d = 9'd272;
			1: d = 9'd210;
			2: d = 9'd156;
			3: d = 9'd110;
			4: d = 9'd72;
			5: d = 9'd42;
			6: d = 9'd20;
			default: d = 9'd6;
		endcase
		return d;
	endfunction

	// Floor of 2^32 divided by the matching divisor.
	function automatic logic [29:0] sin_recip(input int j);
		logic [29:0] r;
		case (j)
			0: r = 30'd15790320;
			1: r = 30'd20452225;
			2: r = 30'd27531841;
			3: r = 30'd39045157;
			4: r = 30'd59652323;
			5: r = 30'd102261126;
			6: r = 30'd214748364;
			default: r = 30'd715827882;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/gbm_quarter_sin.sv
// Pipelined quarter-wave sine on a Q.30 quarter-turn fraction, Horner evaluation.
module gbm_quarter_sin (
	input  logic        clk,
	input  logic [30:0] u,
	output logic [30:0] sine
);

	localparam int HS = gbm_pkg::HORNER_STEPS;

	logic [61:0] xp;
	logic [30:0] x_s1;
	logic [61:0] x2p;
	logic [30:0] x_s2;
	logic [31:0] x2_s2;

	logic [30:0] x_in  [HS];
	logic [31:0] x2_in [HS];
	logic [30:0] s_in  [HS];
	logic [30:0] x_a   [HS];
	logic [31:0] x2_a  [HS];
	logic [31:0] p_a   [HS];
	logic [30:0] x_b   [HS];
	logic [31:0] x2_b  [HS];
	logic [31:0] p_b   [HS];
	logic [29:0] qq_b  [HS];
	logic [30:0] x_c   [HS];
	logic [31:0] x2_c  [HS];
	logic [30:0] s_c   [HS];

	logic [61:0] fp;

	assign xp  = 62'(u) * 62'(gbm_pkg::HALF_PI_Q30);
	assign x2p = 62'(x_s1) * 62'(x_s1);

	always_ff @(posedge clk) begin
		x_s1  <= xp[60:30];
		x_s2  <= x_s1;
		x2_s2 <= x2p[61:30];
	end

	for (genvar j = 0; j < HS; j++) begin : g_step
		localparam logic [8:0]  D = gbm_pkg::sin_div(j);
		localparam logic [29:0] R = gbm_pkg::sin_recip(j);
		logic [62:0] ps;
		logic [61:0] qr;
		logic [38:0] qd;
		logic [38:0] rem;
		logic [30:0] q;

		if (j == 0) begin : g_first
			assign x_in[j]  = x_s2;
			assign x2_in[j] = x2_s2;
			assign s_in[j]  = gbm_pkg::Q30_ONE;
		end else begin : g_next
			assign x_in[j]  = x_c[j-1];
			assign x2_in[j] = x2_c[j-1];
			assign s_in[j]  = s_c[j-1];
		end

		assign ps  = 63'(x2_in[j]) * 63'(s_in[j]);
		assign qr  = 62'(p_a[j]) * 62'(R);
		assign qd  = 39'(qq_b[j]) * 39'(D);
		assign rem = 39'(p_b[j]) - qd;
		assign q   = 31'(qq_b[j]) + ((rem >= 39'(D)) ? 31'd1 : 31'd0);

		always_ff @(posedge clk) begin
			x_a[j]  <= x_in[j];
			x2_a[j] <= x2_in[j];
			p_a[j]  <= ps[61:30];
			x_b[j]  <= x_a[j];
			x2_b[j] <= x2_a[j];
			p_b[j]  <= p_a[j];
			qq_b[j] <= qr[61:32];
			x_c[j]  <= x_b[j];
			x2_c[j] <= x2_b[j];
			s_c[j]  <= gbm_pkg::Q30_ONE - q;
		end
	end

	assign fp = 62'(x_c[HS-1]) * 62'(s_c[HS-1]);

	always_ff @(posedge clk) begin
		sine <= fp[60:30];
	end

endmodule

FILE: rtl/gbm_log_sqrt.sv
// Pipelined radius path: r = sqrt(-2 ln u1) in Q.28 from the radius word.
module gbm_log_sqrt #(
	parameter int UNIFORM_BITS = gbm_pkg::UNIFORM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] k_raw,
	output logic        out_valid,
	output logic [31:0] root
);

	localparam int SQ = gbm_pkg::SQ_STEPS;
	localparam int SR = gbm_pkg::SQRT_STEPS;
	localparam logic [32:0] ONE_UB = 33'd1 << UNIFORM_BITS;
	localparam logic [31:0] MASK = 32'(ONE_UB - 33'd1);

	logic [31:0] k;
	logic [4:0]  e;
	logic        v_s1;
	logic [31:0] m_s1;
	logic [5:0]  lint_s1;

	logic [31:0] m_in  [SQ];
	logic [29:0] f_in  [SQ];
	logic [5:0]  l_in  [SQ];
	logic        v_in  [SQ];
	logic [31:0] sq_m  [SQ];
	logic [29:0] sq_f  [SQ];
	logic [5:0]  sq_l  [SQ];
	logic        sq_v  [SQ];

	logic [35:0] lval;
	logic [46:0] ph_sa;
	logic [46:0] pl_sa;
	logic        v_sa;
	logic [64:0] tot;
	logic [34:0] t_sb;
	logic        v_sb;

	logic [63:0] n_in   [SR];
	logic [63:0] res_in [SR];
	logic        vr_in  [SR];
	logic [63:0] sr_n   [SR];
	logic [63:0] sr_res [SR];
	logic        sr_v   [SR];

	always_comb begin
		k = k_raw & MASK;
		if (k == 32'd0) begin
			k = 32'd1;
		end
		e = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (k[i]) begin
				e = 5'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		m_s1    <= k << (5'd31 - e);
		lint_s1 <= 6'(UNIFORM_BITS) - 6'(e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	for (genvar i = 0; i < SQ; i++) begin : g_sq
		logic [63:0] mm;

		if (i == 0) begin : g_first
			assign m_in[i] = m_s1;
			assign f_in[i] = 30'd0;
			assign l_in[i] = lint_s1;
			assign v_in[i] = v_s1;
		end else begin : g_next
			assign m_in[i] = sq_m[i-1];
			assign f_in[i] = sq_f[i-1];
			assign l_in[i] = sq_l[i-1];
			assign v_in[i] = sq_v[i-1];
		end

		assign mm = 64'(m_in[i]) * 64'(m_in[i]);

		always_ff @(posedge clk) begin
			sq_m[i] <= mm[63] ? mm[63:32] : mm[62:31];
			sq_f[i] <= {f_in[i][28:0], mm[63]};
			sq_l[i] <= l_in[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i] <= 1'b0;
			end else begin
				sq_v[i] <= v_in[i];
			end
		end
	end

	assign lval = {sq_l[SQ-1], 30'd0} - {6'd0, sq_f[SQ-1]};
	assign tot  = {ph_sa, 18'd0} + 65'(pl_sa);

	always_ff @(posedge clk) begin
		ph_sa <= 47'(lval[35:18]) * 47'(gbm_pkg::TWO_LN2_Q28);
		pl_sa <= 47'(lval[17:0]) * 47'(gbm_pkg::TWO_LN2_Q28);
		t_sb  <= tot[64:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
			v_sb <= 1'b0;
		end else begin
			v_sa <= sq_v[SQ-1];
			v_sb <= v_sa;
		end
	end

	for (genvar i = 0; i < SR; i++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;

		if (i == 0) begin : g_first
			assign n_in[i]   = {1'b0, t_sb, 28'd0};
			assign res_in[i] = 64'd0;
			assign vr_in[i]  = v_sb;
		end else begin : g_next
			assign n_in[i]   = sr_n[i-1];
			assign res_in[i] = sr_res[i-1];
			assign vr_in[i]  = sr_v[i-1];
		end

		assign trial = res_in[i] + BIT;

		always_ff @(posedge clk) begin
			if (n_in[i] >= trial) begin
				sr_n[i]   <= n_in[i] - trial;
				sr_res[i] <= (res_in[i] >> 1) + BIT;
			end else begin
				sr_n[i]   <= n_in[i];
				sr_res[i] <= res_in[i] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[i] <= 1'b0;
			end else begin
				sr_v[i] <= vr_in[i];
			end
		end
	end

	assign root      = sr_res[SR-1][31:0];
	assign out_valid = sr_v[SR-1];

endmodule

FILE: rtl/gaussian_box_muller_top.sv
// Top level of the Box-Muller Gaussian pair generator.
//
// A transaction is offered by raising start with two uniform words on in_item;
// it is taken at any rising edge where start is high and busy is low. busy is
// never raised, so one transaction can be taken in every cycle.
// Each transaction yields one result pair on result, shown for exactly one
// cycle while done is high; the receiver takes the pair at the edge that ends
// that cycle. Results leave in the order the transactions arrived.
// The latency is set by the radius path: one normalising stage, thirty
// squaring stages for the logarithm, two stages for the scaling multiply
// and thirty-two square root stages, then three output stages. The angle
// path is shorter and is delayed to line up with it.
// mean_value and spread are written through cfg_we, cfg_index and cfg_wdata
// with no wait; they should change only while no transaction is in flight.
// Reset clears all valid bits, sets mean_value to zero and spread to one.
// The receiver cannot stall the block.
module gaussian_box_muller_top #(
	parameter int UNIFORM_BITS = gbm_pkg::UNIFORM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gbm_pkg::in_item_t   in_item,
	output logic                done,
	output gbm_pkg::out_item_t  result,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_wdata
);

	localparam int QL = gbm_pkg::QSIN_LAT;
	localparam int DL = gbm_pkg::LOG_LAT - gbm_pkg::TRIG_LAT;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic [1:0]  quad;
		logic [30:0] sin_t;
		logic [30:0] cos_t;
	} trig_t;

	logic signed [31:0] mean_q;
	logic [30:0]        spread_q;

	logic        accept;
	logic [31:0] phase;
	logic [1:0]  quad_s1;
	logic [30:0] st_s1;
	logic [30:0] ct_s1;
	logic [1:0]  quad_d [QL];
	logic [30:0] sin_w;
	logic [30:0] cos_w;
	trig_t       trig_d [DL];
	trig_t       trig_w;

	logic        lg_valid;
	logic [31:0] root;

	logic [30:0] cv;
	logic [30:0] sv;
	logic        cneg;
	logic        sneg;
	logic [62:0] rc_s66;
	logic [62:0] rs_s66;
	logic        cneg_s66;
	logic        sneg_s66;
	logic        v_s66;
	logic [63:0] mc;
	logic [63:0] ms;
	logic [35:0] magc_s67;
	logic [35:0] mags_s67;
	logic        cneg_s67;
	logic        sneg_s67;
	logic        v_s67;

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] mean,
		input logic [35:0] mag, input logic neg);
		logic signed [37:0] sum;
		logic signed [31:0] res;
		if (neg) begin
			sum = 38'(mean) - $signed({2'b00, mag});
		end else begin
			sum = 38'(mean) + $signed({2'b00, mag});
		end
		if (sum > 38'sd2147483647) begin
			res = 32'sh7FFF_FFFF;
		end else if (sum < -38'sd2147483648) begin
			res = 32'sh8000_0000;
		end else begin
			res = sum[31:0];
		end
		return res;
	endfunction

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q   <= gbm_pkg::MEAN_RESET;
			spread_q <= gbm_pkg::SPREAD_RESET;
		end else if (cfg_we) begin
			case (gbm_pkg::cfg_reg_t'(cfg_index))
				gbm_pkg::REG_MEAN:   mean_q   <= cfg_wdata;
				gbm_pkg::REG_SPREAD: spread_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	gbm_log_sqrt #(
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_log_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.k_raw(in_item.uniform_radius),
		.out_valid(lg_valid),
		.root(root)
	);

	assign phase = in_item.uniform_angle << (32 - UNIFORM_BITS);

	always_ff @(posedge clk) begin
		quad_s1 <= phase[31:30];
		st_s1   <= {1'b0, phase[29:0]};
		ct_s1   <= gbm_pkg::Q30_ONE - {1'b0, phase[29:0]};
	end

	gbm_quarter_sin u_sin (
		.clk(clk),
		.u(st_s1),
		.sine(sin_w)
	);

	gbm_quarter_sin u_cos (
		.clk(clk),
		.u(ct_s1),
		.sine(cos_w)
	);

	always_ff @(posedge clk) begin
		quad_d[0] <= quad_s1;
		for (int i = 1; i < QL; i++) begin
			quad_d[i] <= quad_d[i-1];
		end
		trig_d[0] <= '{quad: quad_d[QL-1], sin_t: sin_w, cos_t: cos_w};
		for (int i = 1; i < DL; i++) begin
			trig_d[i] <= trig_d[i-1];
		end
	end

	assign trig_w = trig_d[DL-1];

	always_comb begin
		case (quad_t'(trig_w.quad))
			QUAD_0: begin
				cv = trig_w.cos_t; cneg = 1'b0; sv = trig_w.sin_t; sneg = 1'b0;
			end
			QUAD_1: begin
				cv = trig_w.sin_t; cneg = 1'b1; sv = trig_w.cos_t; sneg = 1'b0;
			end
			QUAD_2: begin
				cv = trig_w.cos_t; cneg = 1'b1; sv = trig_w.sin_t; sneg = 1'b1;
			end
			default: begin
				cv = trig_w.sin_t; cneg = 1'b0; sv = trig_w.cos_t; sneg = 1'b1;
			end
		endcase
	end

	assign mc = 64'(spread_q) * 64'(rc_s66[61:30]) + 64'h0800_0000;
	assign ms = 64'(spread_q) * 64'(rs_s66[61:30]) + 64'h0800_0000;

	always_ff @(posedge clk) begin
		rc_s66   <= 63'(root) * 63'(cv);
		rs_s66   <= 63'(root) * 63'(sv);
		cneg_s66 <= cneg;
		sneg_s66 <= sneg;
		magc_s67 <= mc[63:28];
		mags_s67 <= ms[63:28];
		cneg_s67 <= cneg_s66;
		sneg_s67 <= sneg_s66;
		result.normal_cos <= add_sat(mean_q, magc_s67, cneg_s67);
		result.normal_sin <= add_sat(mean_q, mags_s67, sneg_s67);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s66 <= 1'b0;
			v_s67 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s66 <= lg_valid;
			v_s67 <= v_s66;
			done  <= v_s67;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(gbm_pkg::TOTAL_LAT) done)
		else $error("transaction did not produce a result at the expected cycle");

	a_zero_spread: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(spread_q, 2) == 31'd0) |->
		(result.normal_cos == $past(mean_q, 1) && result.normal_sin == $past(mean_q, 1)))
		else $error("zero spread must return the mean on both outputs");

endmodule
